// ===== rtl/core/usp_pkg.sv =====
// Shared types, constants and saturating arithmetic for the upwind scalar advection block.
// No dependencies.
package usp_pkg;

  localparam logic signed [63:0] SAT64 = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [64:0] SAT65 = 65'sh0_7FFF_FFFF_FFFF_FFFF;
  localparam logic [31:0] INT32_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] INT32_MIN = 32'h8000_0000;
  localparam int unsigned QUEUE_DEPTH = 4;

  // Configuration register indexes
  localparam logic REG_TIME_OVER_SPACING = 1'b0;
  localparam logic REG_FLUX_DEAD_BAND    = 1'b1;

  typedef enum logic [2:0] {
    F_IDLE, F_CUR, F_FT, F_TLO, F_THI, F_ADD, F_PUSH_H, F_PUSH_C
  } front_state_t;

  typedef enum logic [1:0] {B_IDLE, B_DIV, B_DONE} back_state_t;

  // One cell waiting for its divide
  typedef struct packed {
    logic signed [63:0] sum;
    logic [31:0]        rho;
    logic               last;
  } usp_entry_t;

  typedef struct packed {
    logic       valid;
    usp_entry_t entry;
  } usp_push_t;

  function automatic logic is_sat(input logic signed [63:0] v);
    is_sat = (v == SAT64) || (v == -SAT64);
  endfunction

  // Saturating add; a saturated operand is sticky
  function automatic logic signed [63:0] add_sat(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
    logic signed [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (is_sat(a)) add_sat = a;
    else if (is_sat(b)) add_sat = b;
    else if (s > SAT65) add_sat = SAT64;
    else if (s < -SAT65) add_sat = -SAT64;
    else add_sat = s[63:0];
  endfunction

  function automatic logic [31:0] abs32(input logic signed [31:0] x);
    abs32 = x[31] ? 32'(-x) : 32'(x);
  endfunction

endpackage

// ===== rtl/core/usp_ifs.sv =====
// Valid/ready channel interfaces: cell words in, result words out, configuration writes.
// No dependencies.
interface usp_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] scalar_value;
  logic signed [31:0] face_flux;
  logic [31:0]        density_old;
  logic [31:0]        density_new;
  logic               first_cell;
  logic               last_cell;
  modport source(output valid, scalar_value, face_flux, density_old, density_new,
                 first_cell, last_cell, input ready);
  modport sink(input valid, scalar_value, face_flux, density_old, density_new,
               first_cell, last_cell, output ready);
endinterface

interface usp_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] scalar_out;
  logic               divide_fault;
  logic               last_of_line;
  modport source(output valid, scalar_out, divide_fault, last_of_line, input ready);
  modport sink(input valid, scalar_out, divide_fault, last_of_line, output ready);
endinterface

interface usp_cfg_if;
  logic        valid;
  logic        ready;
  logic        index;
  logic [23:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

// ===== rtl/core/usp_front.sv =====
// Front end: accepts cells, forms conserved sums and applies face transfers.
// Depends on usp_pkg and usp_in_if.
module usp_front #(
  parameter int FRAC_BITS = 16
) (
  input  logic                clk,
  input  logic                rst,
  usp_in_if.sink              cells,
  input  logic [23:0]         tos,
  input  logic [15:0]         band,
  output usp_pkg::usp_push_t  push,
  input  logic                push_ready
);
  import usp_pkg::*;

  front_state_t state, state_next;

  logic signed [31:0] q_r, flux_r;
  logic [31:0]        rho_old_r, rho_new_r;
  logic               first_r, last_r;
  logic signed [63:0] cur;
  logic [47:0]        a_mag;
  logic               a_neg, up_neg;
  logic [31:0]        up_mag;
  logic [79:0]        acc;
  logic signed [31:0] held_scalar;
  logic signed [63:0] held_sum;
  logic [31:0]        held_rho;
  logic               held_valid;

  logic [31:0]        ma, mb;
  logic [63:0]        prod, prod_sh;
  logic signed [31:0] band_s;
  logic               gt, lt;
  logic signed [31:0] up;
  logic [79:0]        t_sh;
  logic signed [63:0] t_mag, t_val;

  // Upwind choice against the dead band
  assign band_s = $signed({16'b0, band});
  assign gt     = flux_r > band_s;
  assign lt     = flux_r < -band_s;
  assign up     = gt ? held_scalar : q_r;

  // Shared multiplier, operands picked by step
  always_comb begin
    case (state)
      F_CUR:   begin ma = abs32(q_r);              mb = rho_old_r;     end
      F_FT:    begin ma = abs32(flux_r);           mb = {8'b0, tos};   end
      F_TLO:   begin ma = a_mag[31:0];             mb = up_mag;        end
      F_THI:   begin ma = {16'b0, a_mag[47:32]};   mb = up_mag;        end
      default: begin ma = '0;                      mb = '0;            end
    endcase
  end
  assign prod    = ma * mb;
  assign prod_sh = prod >> FRAC_BITS;

  // Transfer magnitude, saturated to 63 bits
  assign t_sh  = acc >> FRAC_BITS;
  assign t_mag = (|t_sh[79:63]) ? SAT64 : $signed(t_sh[63:0]);
  assign t_val = (a_neg ^ up_neg) ? -t_mag : t_mag;

  always_ff @(posedge clk) begin
    if (rst) state <= F_IDLE;
    else     state <= state_next;
  end

  // Sequencer: next state, handshake and queue pushes
  always_comb begin
    state_next  = state;
    cells.ready = 1'b0;
    push        = '0;
    unique case (state)
      F_IDLE: begin
        cells.ready = 1'b1;
        if (cells.valid) state_next = F_CUR;
      end
      F_CUR:  state_next = (held_valid && !first_r && (gt || lt)) ? F_FT : F_PUSH_H;
      F_FT:   state_next = F_TLO;
      F_TLO:  state_next = F_THI;
      F_THI:  state_next = F_ADD;
      F_ADD:  state_next = F_PUSH_H;
      F_PUSH_H: begin
        push.valid       = held_valid;
        push.entry.sum   = held_sum;
        push.entry.rho   = held_rho;
        push.entry.last  = 1'b0;
        if (!held_valid || push_ready) state_next = F_PUSH_C;
      end
      F_PUSH_C: begin
        push.valid       = last_r;
        push.entry.sum   = cur;
        push.entry.rho   = rho_new_r;
        push.entry.last  = 1'b1;
        if (!last_r || push_ready) state_next = F_IDLE;
      end
      default: state_next = F_IDLE;
    endcase
  end

  // Held-cell flag
  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (state == F_PUSH_H && held_valid && push_ready) begin
      held_valid <= 1'b0;
    end else if (state == F_PUSH_C && !last_r) begin
      held_valid <= 1'b1;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    case (state)
      F_IDLE: begin
        q_r       <= cells.scalar_value;
        flux_r    <= cells.face_flux;
        rho_old_r <= cells.density_old;
        rho_new_r <= cells.density_new;
        first_r   <= cells.first_cell;
        last_r    <= cells.last_cell;
      end
      F_CUR: begin
        cur    <= q_r[31] ? -$signed(prod_sh) : $signed(prod_sh);
        up_mag <= abs32(up);
        up_neg <= up[31];
      end
      F_FT: begin
        a_mag <= prod_sh[47:0];
        a_neg <= flux_r[31];
      end
      F_TLO: acc <= {16'b0, prod};
      F_THI: acc <= acc + (80'(prod) << 32);
      F_ADD: begin
        cur      <= add_sat(cur, t_val);
        held_sum <= add_sat(held_sum, -t_val);
      end
      F_PUSH_C: begin
        if (!last_r) begin
          held_scalar <= q_r;
          held_sum    <= cur;
          held_rho    <= rho_new_r;
        end
      end
      default: ;
    endcase
  end

endmodule

// ===== rtl/core/usp_queue.sv =====
// Short queue of cells waiting for the divider, between front and back.
// Depends on usp_pkg.
module usp_queue (
  input  logic               clk,
  input  logic               rst,
  input  usp_pkg::usp_push_t push,
  output logic               push_ready,
  output usp_pkg::usp_push_t head,
  input  logic               pop
);
  import usp_pkg::*;

  localparam int AW = $clog2(QUEUE_DEPTH);

  usp_entry_t    slots [QUEUE_DEPTH];
  logic [AW-1:0] wr_ptr, rd_ptr;
  logic [AW:0]   count;
  logic          do_push, do_pop;

  assign push_ready = count != (AW+1)'(QUEUE_DEPTH);
  assign do_push    = push.valid && push_ready;
  assign do_pop     = pop && count != '0;
  assign head.valid = count != '0;
  assign head.entry = slots[rd_ptr];

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= rd_ptr + 1'b1;
      count <= count + (AW+1)'(do_push) - (AW+1)'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) slots[wr_ptr] <= push.entry;
  end

endmodule

// ===== rtl/core/usp_back.sv =====
// Back end: restoring divide of each conserved sum by its new density, output register.
// Depends on usp_pkg and usp_out_if.
module usp_back #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  usp_pkg::usp_push_t head,
  output logic               pop,
  usp_out_if.source          results
);
  import usp_pkg::*;

  localparam int QB = 33;

  back_state_t state, state_next;

  logic          neg_r, last_r, imm_r;
  logic [31:0]   rho_r, rem, imm_val;
  logic [QB-1:0] dlo, qbits;
  logic [5:0]    step;
  logic          out_valid;
  logic [31:0]   out_val;
  logic          out_fault, out_last;

  logic               s_neg, s_sat, ovf, imm;
  logic [63:0]        mag, high;
  logic [31:0]        imm_v;
  logic [QB:0]        r2;
  logic               ge;
  logic [QB-1:0]      bound;
  logic               fin_fault;
  logic [31:0]        fin_val;
  logic               load_out;

  // Setup decode of the queue head
  assign s_neg = head.entry.sum[63];
  assign s_sat = is_sat(head.entry.sum);
  assign mag   = s_neg ? 64'(-head.entry.sum) : 64'(head.entry.sum);
  assign high  = mag >> (QB - FRAC_BITS);
  assign ovf   = high >= {32'b0, head.entry.rho};
  assign imm   = s_sat || head.entry.rho == '0 || ovf;
  always_comb begin
    if (head.entry.rho == '0 && !s_sat)
      imm_v = s_neg ? INT32_MIN : (head.entry.sum != '0 ? INT32_MAX : 32'h0);
    else
      imm_v = s_neg ? INT32_MIN : INT32_MAX;
  end

  // One quotient bit a cycle
  assign r2 = {1'b0, rem, dlo[QB-1]};
  assign ge = r2 >= {2'b0, rho_r};

  // Final range check
  assign bound     = neg_r ? QB'(INT32_MIN) : QB'(INT32_MAX);
  assign fin_fault = imm_r || qbits > bound;
  always_comb begin
    if (imm_r)          fin_val = imm_val;
    else if (fin_fault) fin_val = neg_r ? INT32_MIN : INT32_MAX;
    else                fin_val = neg_r ? 32'(-qbits) : qbits[31:0];
  end

  assign load_out = state == B_DONE && (!out_valid || results.ready);

  always_ff @(posedge clk) begin
    if (rst) state <= B_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    pop        = 1'b0;
    unique case (state)
      B_IDLE: begin
        if (head.valid) begin
          pop        = 1'b1;
          state_next = imm ? B_DONE : B_DIV;
        end
      end
      B_DIV:  if (step == 6'(QB - 1)) state_next = B_DONE;
      B_DONE: if (load_out) state_next = B_IDLE;
      default: state_next = B_IDLE;
    endcase
  end

  // Divider registers
  always_ff @(posedge clk) begin
    case (state)
      B_IDLE: begin
        neg_r   <= s_neg;
        last_r  <= head.entry.last;
        rho_r   <= head.entry.rho;
        imm_r   <= imm;
        imm_val <= imm_v;
        rem     <= high[31:0];
        dlo     <= QB'(mag << FRAC_BITS);
        qbits   <= '0;
        step    <= '0;
      end
      B_DIV: begin
        rem   <= ge ? 32'(r2 - {2'b0, rho_r}) : r2[31:0];
        dlo   <= dlo << 1;
        qbits <= {qbits[QB-2:0], ge};
        step  <= step + 1'b1;
      end
      default: ;
    endcase
  end

  // Output word register
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (load_out) out_valid <= 1'b1;
    else if (results.ready) out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_val   <= fin_val;
      out_fault <= fin_fault;
      out_last  <= last_r;
    end
  end

  assign results.valid        = out_valid;
  assign results.scalar_out   = $signed(out_val);
  assign results.divide_fault = out_fault;
  assign results.last_of_line = out_last;

endmodule

// ===== rtl/core/upwind_passive_scalar_advect.sv =====
// Top level of the 1D donor-cell advection block: config registers, front, queue, back.
// Depends on usp_pkg, usp_ifs, usp_front, usp_queue and usp_back.
//
//  channel  | dir | word
//  ---------+-----+----------------------------------------------------------
//  cfg      | in  | index, data (time_over_spacing, flux_dead_band)
//  cells    | in  | scalar_value, face_flux, density_old/new, first/last_cell
//  results  | out | scalar_out, divide_fault, last_of_line
//
// The front takes a new cell only once it has pushed the last one; a face transfer
// adds the FT, TLO, THI and ADD steps (one shared 32x32 multiplier runs the
// conserved-sum and transfer products). The back takes one result at a time through
// its bit-serial divider, skipping it when no divide is needed (saturated sum, zero
// density or quotient overflow seen up front); the divider sets the sustained rate.
// A 4-entry queue lets the front run ahead while the back or results stalls.
// Reset (rst, synchronous) empties the queue and drops any held cell.
module upwind_passive_scalar_advect #(
  parameter int FRAC_BITS = 16
) (
  input logic       clk,
  input logic       rst,
  usp_cfg_if.sink   cfg,
  usp_in_if.sink    cells,
  usp_out_if.source results
);
  import usp_pkg::*;

  logic [23:0] time_over_spacing;
  logic [15:0] flux_dead_band;
  usp_push_t   push, head;
  logic        push_ready, pop;

  // Configuration registers
  assign cfg.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      time_over_spacing <= '0;
      flux_dead_band    <= '0;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_TIME_OVER_SPACING: time_over_spacing <= cfg.data;
        REG_FLUX_DEAD_BAND:    flux_dead_band    <= cfg.data[15:0];
        default: ;
      endcase
    end
  end

  usp_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk(clk), .rst(rst), .cells(cells), .tos(time_over_spacing),
    .band(flux_dead_band), .push(push), .push_ready(push_ready)
  );

  usp_queue u_queue (
    .clk(clk), .rst(rst), .push(push), .push_ready(push_ready),
    .head(head), .pop(pop)
  );

  usp_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk(clk), .rst(rst), .head(head), .pop(pop), .results(results)
  );

`ifndef NO_ASSERTIONS
  a_one_cell: assert property (@(posedge clk) disable iff (rst)
    cells.valid && cells.ready |=> !cells.ready)
    else $error("front took a second cell while busy");
  a_pop_ok: assert property (@(posedge clk) disable iff (rst)
    pop |-> head.valid)
    else $error("back popped an empty queue");
  a_reset_out: assert property (@(posedge clk)
    rst |=> !results.valid)
    else $error("result word valid after reset");
  a_push_kept: assert property (@(posedge clk) disable iff (rst)
    push.valid && !push_ready |=> push.valid)
    else $error("front dropped a queued cell");
`endif

endmodule
